@@ sv/fogb_pkg.sv @@
// Package for the exponential fog blend: widths, register indexes and the
// exponential attenuation table, which is built once at elaboration.
// Depends on nothing; every module of the block imports it.
package fogb_pkg;

    // Fraction bits of the exponent, which also sets the depth of the table.
    localparam int EXP_TABLE_BITS = 8;
    localparam int ROM_SIZE       = 1 << EXP_TABLE_BITS;

    // log2(e) in Q.8 and the widths of the depth path.
    localparam int LOG2E_Q8 = 369;
    localparam int LOG2E_W  = 9;
    localparam int DIST_W   = 16;
    localparam int DENS_W   = 16;
    localparam int DPROD_W  = DIST_W + DENS_W;
    localparam int X_W      = DPROD_W - 12;
    localparam int YPROD_W  = X_W + LOG2E_W;
    localparam int Y_W      = YPROD_W - (16 - EXP_TABLE_BITS);
    localparam int SH_W     = Y_W - EXP_TABLE_BITS;
    localparam int ATT_W    = 16;
    localparam int COL_W    = 8;
    localparam int NUM_COL  = 3;

    // Blend product widths: color times attenuation, fog times its complement.
    localparam int PC_W  = COL_W + ATT_W;
    localparam int NA_W  = ATT_W + 1;
    localparam int PF_W  = COL_W + NA_W;
    localparam int SUM_W = PF_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOG_DENSITY = 4'd0,
        CFG_FOG_RED     = 4'd1,
        CFG_FOG_GREEN   = 4'd2,
        CFG_FOG_BLUE    = 4'd3
    } t_cfg_idx;

    typedef logic [ROM_SIZE-1:0][ATT_W-1:0] t_exp_rom;

    // (a * b) >> 62 on Q62 values below 2^63.
    function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Floor square root of a Q62 value below one, one bit per step.
    function automatic logic [63:0] q62_sqrt(logic [63:0] v);
        logic [63:0] x;
        logic [63:0] cand;
        x = 64'd0;
        for (int b = 61; b >= 0; b--) begin
            cand = x | (64'd1 << b);
            if (q62_mul(cand, cand) <= v) begin
                x = cand;
            end
        end
        return x;
    endfunction

    // Table entry f holds min(65535, round(65536 * 2^(-f / ROM_SIZE))).
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] roots [0:EXP_TABLE_BITS];
        logic [63:0] v;
        logic [63:0] r;
        roots[0] = 64'd1 << 61;
        for (int k = 1; k <= EXP_TABLE_BITS; k++) begin
            roots[k] = q62_sqrt(roots[k-1]);
        end
        for (int f = 0; f < ROM_SIZE; f++) begin
            v = 64'd1 << 62;
            for (int m = 0; m < EXP_TABLE_BITS; m++) begin
                if (((f >> (EXP_TABLE_BITS - 1 - m)) & 1) != 0) begin
                    v = q62_mul(v, roots[m+1]);
                end
            end
            r = (v + (64'd1 << 45)) >> 46;
            rom[f] = (r > 64'd65535) ? {ATT_W{1'b1}} : r[ATT_W-1:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

@@ sv/fogb_atten.sv @@
// Attenuation lookup: splits the log2 depth into a table index and a shift.
// Depends on fogb_pkg for the widths and the exponential table.
module fogb_atten
    import fogb_pkg::*;
(
    input  logic [Y_W-1:0]   i_y,
    output logic [ATT_W-1:0] o_att
);

    logic [EXP_TABLE_BITS-1:0] frac;
    logic [SH_W-1:0]           sh;
    logic                      sat;

    // Fraction picks the table entry, integer part shifts it down.
    assign frac = i_y[EXP_TABLE_BITS-1:0];
    assign sh   = i_y[Y_W-1:EXP_TABLE_BITS];
    assign sat  = |sh[SH_W-1:4];

    // Sixteen or more halvings leave nothing of the surface color.
    assign o_att = sat ? '0 : (EXP_ROM[frac] >> sh[3:0]);

endmodule

@@ sv/exponential_fog_blend.sv @@
// Top level of the exponential fog blend: five-stage pixel pipeline and
// configuration registers. Depends on fogb_pkg and fogb_atten.
//
// Usage:
//   Pixel input: i_valid / o_stall carry one RGBA pixel and its view distance
//   per request. Pixel output: o_valid / i_stall carry the fogged pixel.
//   A request moves at a clock edge where valid is high and stall is low.
//   Configuration: i_cfg_valid / o_cfg_ready write density (index 0) and the
//   fog color (indexes 1 to 3); o_cfg_ready is always high. Write only while
//   no pixel is in flight.
//   An accepted pixel moves through the five pipeline registers to the output.
//   Throughput: one pixel per cycle while i_stall is low; each stage holds
//   one pixel, and a multiplier rank, the table lookup or the final adder
//   lies in front of each of the five pipeline registers.
//   Stall: when i_stall holds the output, the stages behind it keep filling
//   any empty slots; o_stall rises only once every stage holds a pixel.
//   Reset: i_rst_n (synchronous, active low) empties the pipeline and sets
//   density and fog color to zero.
module exponential_fog_blend
    import fogb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COL_W-1:0]      i_in_red,
    input  logic [COL_W-1:0]      i_in_green,
    input  logic [COL_W-1:0]      i_in_blue,
    input  logic [COL_W-1:0]      i_in_alpha,
    input  logic [DIST_W-1:0]     i_view_distance,
    // pixel output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COL_W-1:0]      o_out_red,
    output logic [COL_W-1:0]      o_out_green,
    output logic [COL_W-1:0]      o_out_blue,
    output logic [COL_W-1:0]      o_out_alpha,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [DENS_W-1:0]              r_fog_density;
    logic [NUM_COL-1:0][COL_W-1:0]  r_fog_col;

    // Stage valid bits and enables.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // Stage payloads.
    logic [X_W-1:0]                 r_x;
    logic [Y_W-1:0]                 r_y;
    logic [ATT_W-1:0]               r_att;
    logic [NUM_COL-1:0][COL_W-1:0]  r_col1, r_col2, r_col3;
    logic [COL_W-1:0]               r_alpha1, r_alpha2, r_alpha3, r_alpha4, r_alpha5;
    logic [NUM_COL-1:0][PC_W-1:0]   r_pc;
    logic [NUM_COL-1:0][PF_W-1:0]   r_pf;
    logic [NUM_COL-1:0][COL_W-1:0]  r_out_col;

    // Next values.
    logic [DPROD_W-1:0]             n_dprod;
    logic [YPROD_W-1:0]             n_yprod;
    logic [ATT_W-1:0]               n_att;
    logic [NUM_COL-1:0][COL_W-1:0]  in_col;
    logic [NUM_COL-1:0][PC_W-1:0]   n_pc;
    logic [NUM_COL-1:0][PF_W-1:0]   n_pf;
    logic [NUM_COL-1:0][COL_W-1:0]  n_out_col;
    logic [NUM_COL-1:0][SUM_W-1:0]  sum;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fog_density <= '0;
            r_fog_col     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOG_DENSITY: r_fog_density <= i_cfg_data;
                CFG_FOG_RED:     r_fog_col[0]  <= i_cfg_data[COL_W-1:0];
                CFG_FOG_GREEN:   r_fog_col[1]  <= i_cfg_data[COL_W-1:0];
                CFG_FOG_BLUE:    r_fog_col[2]  <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its successor moves on.
    assign en5     = !r_v5 || !i_stall;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Stage 1: optical depth x = density * distance in Q.8.
    assign in_col  = {i_in_blue, i_in_green, i_in_red};
    assign n_dprod = DPROD_W'(r_fog_density) * DPROD_W'(i_view_distance);

    // Stage 2: convert to base two, y = x * log2(e).
    assign n_yprod = YPROD_W'(r_x) * YPROD_W'(LOG2E_Q8);

    // Stage 3: table lookup and shift give the attenuation.
    fogb_atten u_atten (
        .i_y   (r_y),
        .o_att (n_att)
    );

    // Stage 4: one product pair per color lane; stage 5 sums and truncates.
    always_comb begin
        for (int i = 0; i < NUM_COL; i++) begin
            n_pc[i]      = PC_W'(r_col3[i]) * PC_W'(r_att);
            n_pf[i]      = PF_W'(r_fog_col[i]) *
                           PF_W'(NA_W'(1 << ATT_W) - NA_W'(r_att));
            sum[i]       = SUM_W'(r_pc[i]) + r_pf[i];
            n_out_col[i] = sum[i][ATT_W+COL_W-1:ATT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_x      <= n_dprod[DPROD_W-1:12];
            r_col1   <= in_col;
            r_alpha1 <= i_in_alpha;
        end
        if (en2 && r_v1) begin
            r_y      <= n_yprod[YPROD_W-1:16-EXP_TABLE_BITS];
            r_col2   <= r_col1;
            r_alpha2 <= r_alpha1;
        end
        if (en3 && r_v2) begin
            r_att    <= n_att;
            r_col3   <= r_col2;
            r_alpha3 <= r_alpha2;
        end
        if (en4 && r_v3) begin
            r_pc     <= n_pc;
            r_pf     <= n_pf;
            r_alpha4 <= r_alpha3;
        end
        if (en5 && r_v4) begin
            r_out_col <= n_out_col;
            r_alpha5  <= r_alpha4;
        end
    end

    assign o_valid     = r_v5;
    assign o_out_red   = r_out_col[0];
    assign o_out_green = r_out_col[1];
    assign o_out_blue  = r_out_col[2];
    assign o_out_alpha = r_alpha5;

    // The input side is held off only when every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall))
        else $error("input stalled while the pipeline has a free stage");

    // A blocked stage keeps its pixel.
    a_stage4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !en4) |=> (r_v4 && $stable(r_pc) && $stable(r_pf)))
        else $error("blend products overwritten while blocked");

    // A depth of sixteen halvings or more drives the attenuation to zero.
    a_att_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en3 && r_v2 && (|r_y[Y_W-1:EXP_TABLE_BITS+4])) |=> (r_att == '0))
        else $error("saturated depth left a nonzero attenuation");

endmodule
